[rtl/rmp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmp_pkg
// Shared types and constants of the region-of-interest max pooling unit.
// ----------------------------------------------------------------------------
package rmp_pkg;

  // field widths fixed by the interface
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CHAN_W     = 3;
  localparam int POS_W      = 6;
  localparam int VAL_W      = 16;
  localparam int COORD_W    = 16;
  localparam int IDX_W      = 13;
  localparam int BIN_W      = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_ROWS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_COLS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 3'd4;

  // configuration reset values
  localparam logic [15:0] SCALE_RST = 16'd4096;
  localparam logic [3:0]  POOL_RST  = 4'd7;
  localparam logic [6:0]  MAP_RST   = 7'd64;

  // opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // coordinate select codes for the scaling multiplier
  localparam logic [1:0] CRD_XS = 2'd0;
  localparam logic [1:0] CRD_YS = 2'd1;
  localparam logic [1:0] CRD_XE = 2'd2;
  localparam logic [1:0] CRD_YE = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic       write;
    logic       query_load;
    logic       scale_go;
    logic [1:0] scale_idx;
    logic       size_calc;
    logic       div_start;
    logic       edges_init;
    logic       bin_start;
    logic       scan;
    logic       emit;
    logic       next_row;
    logic       next_col;
  } rmp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic div_done;
    logic bin_empty;
    logic scan_last;
    logic out_free;
    logic last_row;
    logic last_col;
  } rmp_status_t;

endpackage
`default_nettype wire

[rtl/rmp_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmp_div
// Restoring divider, one quotient bit per cycle; quotient and remainder hold
// until the next start.
// ----------------------------------------------------------------------------
module rmp_div #(
  parameter int NW = 8,
  parameter int DW = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quo,
  output logic [DW-1:0]      rem
);

  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW:0]   trial;
  logic          ge;

  // trial subtraction of the next dividend bit
  assign trial = {rem, quo[NW-1]};
  assign ge    = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= CW'(cnt + CW'(1));
      if (cnt == CW'(NW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // quotient shifts in where the dividend shifts out
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[NW-2:0], ge};
      rem <= ge ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
    end
  end

endmodule
`default_nettype wire

[rtl/rmp_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmp_ctrl
// Sequencer: scales the region, sizes the bins, scans each bin and hands
// each bin result to the output register.
// ----------------------------------------------------------------------------
module rmp_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 opcode,
  output logic                      in_stall,
  output rmp_pkg::rmp_cmd_t         cmd,
  input  wire rmp_pkg::rmp_status_t status
);
  import rmp_pkg::*;

  typedef enum logic [2:0] {
    IDLE, SCALE, SIZE, DIV_GO, DIV_WAIT, BIN_SETUP, SCAN, EMIT
  } state_t;

  state_t     state, state_next;
  logic [2:0] scnt;
  logic       drain, drain_next;

  assign in_stall = (state != IDLE);

  // command decode and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    drain_next = 1'b0;
    case (state)
      IDLE: begin
        cmd.write = in_valid && (opcode == OP_WRITE);
        if (in_valid && (opcode == OP_QUERY)) begin
          cmd.query_load = 1'b1;
          state_next     = SCALE;
        end
      end
      SCALE: begin
        cmd.scale_go  = (scnt < 3'd4);
        cmd.scale_idx = scnt[1:0];
        if (scnt == 3'd4) state_next = SIZE;
      end
      SIZE: begin
        cmd.size_calc = 1'b1;
        state_next    = DIV_GO;
      end
      DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = DIV_WAIT;
      end
      DIV_WAIT: begin
        if (status.div_done) begin
          cmd.edges_init = 1'b1;
          state_next     = BIN_SETUP;
        end
      end
      BIN_SETUP: begin
        cmd.bin_start = 1'b1;
        state_next    = status.bin_empty ? EMIT : SCAN;
      end
      SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_next = EMIT;
          drain_next = 1'b1;
        end
      end
      EMIT: begin
        // the drain flag holds off emit until the last read has reached the compare
        if (!drain && status.out_free) begin
          cmd.emit = 1'b1;
          if (status.last_row && status.last_col) begin
            state_next = IDLE;
          end else if (status.last_col) begin
            cmd.next_row = 1'b1;
            state_next   = BIN_SETUP;
          end else begin
            cmd.next_col = 1'b1;
            state_next   = BIN_SETUP;
          end
        end
      end
      default: state_next = IDLE;
    endcase
  end

  // state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      scnt  <= '0;
      drain <= 1'b0;
    end else begin
      state <= state_next;
      drain <= drain_next;
      if (state == SCALE) scnt <= 3'(scnt + 3'd1);
      else scnt <= '0;
    end
  end

endmodule
`default_nettype wire

[rtl/rmp_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmp_dp
// Datapath: feature store, coordinate scaling, bin edge stepping, scan and
// compare, and the output register.
// ----------------------------------------------------------------------------
module rmp_dp #(
  parameter int CHANNELS   = 8,
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int MAX_POOLED = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire rmp_pkg::rmp_cmd_t                  cmd,
  output rmp_pkg::rmp_status_t                    status,
  input  wire logic [15:0]                        cfg_scale,
  input  wire logic [3:0]                         cfg_ph,
  input  wire logic [3:0]                         cfg_pw,
  input  wire logic [6:0]                         cfg_mh,
  input  wire logic [6:0]                         cfg_mw,
  input  wire logic [rmp_pkg::CHAN_W-1:0]         channel,
  input  wire logic [rmp_pkg::POS_W-1:0]          row,
  input  wire logic [rmp_pkg::POS_W-1:0]          col,
  input  wire logic signed [rmp_pkg::VAL_W-1:0]   value,
  input  wire logic [rmp_pkg::COORD_W-1:0]        roi_x_start,
  input  wire logic [rmp_pkg::COORD_W-1:0]        roi_y_start,
  input  wire logic [rmp_pkg::COORD_W-1:0]        roi_x_end,
  input  wire logic [rmp_pkg::COORD_W-1:0]        roi_y_end,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [rmp_pkg::VAL_W-1:0]        max_value,
  output logic signed [rmp_pkg::IDX_W-1:0]        argmax_index,
  output logic [rmp_pkg::BIN_W-1:0]               bin_row,
  output logic [rmp_pkg::BIN_W-1:0]               bin_col,
  output logic                                    last
);
  import rmp_pkg::*;

  localparam int HW    = $clog2(MAX_ROWS + 1);
  localparam int WW    = $clog2(MAX_COLS + 1);
  localparam int MAXD  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int DNW   = $clog2(MAXD + 2);
  localparam int EW    = DNW + 1;
  localparam int DEPTH = CHANNELS * MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int PLANE = MAX_ROWS * MAX_COLS;

  // saturated configuration
  logic [3:0]    ph_s, pw_s;
  logic [HW-1:0] mh_s;
  logic [WW-1:0] mw_s;

  always_comb begin
    if (cfg_ph == 4'd0) ph_s = 4'd1;
    else if (32'(cfg_ph) > MAX_POOLED) ph_s = 4'(MAX_POOLED);
    else ph_s = cfg_ph;
    if (cfg_pw == 4'd0) pw_s = 4'd1;
    else if (32'(cfg_pw) > MAX_POOLED) pw_s = 4'(MAX_POOLED);
    else pw_s = cfg_pw;
    if (cfg_mh == 7'd0) mh_s = HW'(1);
    else if (32'(cfg_mh) > MAX_ROWS) mh_s = HW'(MAX_ROWS);
    else mh_s = HW'(cfg_mh);
    if (cfg_mw == 7'd0) mw_s = WW'(1);
    else if (32'(cfg_mw) > MAX_COLS) mw_s = WW'(MAX_COLS);
    else mw_s = WW'(cfg_mw);
  end

  // query registers
  logic [CHAN_W-1:0]  q_ch;
  logic [COORD_W-1:0] q_xs, q_ys, q_xe, q_ye;
  logic               ch_ok;

  always_ff @(posedge clk) begin
    if (cmd.query_load) begin
      q_ch <= channel;
      q_xs <= roi_x_start;
      q_ys <= roi_y_start;
      q_xe <= roi_x_end;
      q_ye <= roi_y_end;
    end
  end

  assign ch_ok = (32'(q_ch) < CHANNELS);

  // coordinate scaling: multiply, then round half up and clamp
  logic [COORD_W-1:0] sel_coord;
  logic [31:0]        prod;
  logic [1:0]         p_idx;
  logic               p_vld;
  logic [32:0]        rsum;
  logic [12:0]        rnd;
  logic [WW-1:0]      rnd_x;
  logic [HW-1:0]      rnd_y;
  logic [WW-1:0]      xs, xe;
  logic [HW-1:0]      ys, ye;

  always_comb begin
    case (cmd.scale_idx)
      CRD_XS:  sel_coord = q_xs;
      CRD_YS:  sel_coord = q_ys;
      CRD_XE:  sel_coord = q_xe;
      CRD_YE:  sel_coord = q_ye;
      default: sel_coord = q_xs;
    endcase
  end

  assign rsum  = 33'(prod) + 33'(32'h0008_0000);
  assign rnd   = rsum[32:20];
  assign rnd_x = (32'(rnd) > 32'(mw_s)) ? mw_s : WW'(rnd);
  assign rnd_y = (32'(rnd) > 32'(mh_s)) ? mh_s : HW'(rnd);

  always_ff @(posedge clk) begin
    if (rst) p_vld <= 1'b0;
    else p_vld <= cmd.scale_go;
  end

  always_ff @(posedge clk) begin
    if (cmd.scale_go) begin
      prod  <= 32'(sel_coord) * 32'(cfg_scale);
      p_idx <= cmd.scale_idx;
    end
    if (p_vld) begin
      case (p_idx)
        CRD_XS:  xs <= rnd_x;
        CRD_YS:  ys <= rnd_y;
        CRD_XE:  xe <= rnd_x;
        CRD_YE:  ye <= rnd_y;
        default: xs <= rnd_x;
      endcase
    end
  end

  // region size, at least one
  logic [DNW-1:0] rh, rw;

  always_ff @(posedge clk) begin
    if (cmd.size_calc) begin
      rh <= (ye >= ys) ? DNW'(DNW'(ye) - DNW'(ys) + DNW'(1)) : DNW'(1);
      rw <= (xe >= xs) ? DNW'(DNW'(xe) - DNW'(xs) + DNW'(1)) : DNW'(1);
    end
  end

  // size / pooled for rows and columns
  logic           done_h, done_w;
  logic [DNW-1:0] quo_h, quo_w;
  logic [3:0]     rem_h, rem_w;

  rmp_div #(.NW(DNW), .DW(4)) u_div_h (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(rh), .den(ph_s),
    .done(done_h), .quo(quo_h), .rem(rem_h)
  );

  rmp_div #(.NW(DNW), .DW(4)) u_div_w (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(rw), .den(pw_s),
    .done(done_w), .quo(quo_w), .rem(rem_w)
  );

  // advance a quotient/remainder pair by one size/pooled step
  function automatic logic [DNW+3:0] edge_step(
    input logic [DNW-1:0] q,
    input logic [3:0]     r,
    input logic [DNW-1:0] dq,
    input logic [3:0]     dr,
    input logic [3:0]     p
  );
    logic [4:0]     s;
    logic [DNW+3:0] res;
    s = {1'b0, r} + {1'b0, dr};
    if (s >= {1'b0, p}) res = {DNW'(q + dq + DNW'(1)), 4'(s - {1'b0, p})};
    else res = {DNW'(q + dq), s[3:0]};
    return res;
  endfunction

  // bin edge accumulators: start uses floor, end uses ceiling
  logic [DNW-1:0] rs_q, re_q, cs_q, ce_q;
  logic [3:0]     rs_r, re_r, cs_r, ce_r;
  logic [BIN_W-1:0] h_cnt, w_cnt;

  always_ff @(posedge clk) begin
    if (cmd.edges_init || cmd.next_row) begin
      cs_q <= '0;
      cs_r <= '0;
      ce_q <= DNW'(quo_w + DNW'(rem_w != 4'd0));
      ce_r <= (rem_w != 4'd0) ? 4'(rem_w - 4'd1) : 4'(pw_s - 4'd1);
    end else if (cmd.next_col) begin
      {cs_q, cs_r} <= edge_step(cs_q, cs_r, quo_w, rem_w, pw_s);
      {ce_q, ce_r} <= edge_step(ce_q, ce_r, quo_w, rem_w, pw_s);
    end
    if (cmd.edges_init) begin
      rs_q <= '0;
      rs_r <= '0;
      re_q <= DNW'(quo_h + DNW'(rem_h != 4'd0));
      re_r <= (rem_h != 4'd0) ? 4'(rem_h - 4'd1) : 4'(ph_s - 4'd1);
    end else if (cmd.next_row) begin
      {rs_q, rs_r} <= edge_step(rs_q, rs_r, quo_h, rem_h, ph_s);
      {re_q, re_r} <= edge_step(re_q, re_r, quo_h, rem_h, ph_s);
    end
  end

  // bin counters
  always_ff @(posedge clk) begin
    if (rst) begin
      h_cnt <= '0;
      w_cnt <= '0;
    end else if (cmd.edges_init) begin
      h_cnt <= '0;
      w_cnt <= '0;
    end else if (cmd.next_row) begin
      h_cnt <= BIN_W'(h_cnt + BIN_W'(1));
      w_cnt <= '0;
    end else if (cmd.next_col) begin
      w_cnt <= BIN_W'(w_cnt + BIN_W'(1));
    end
  end

  // clamped bin edges
  logic [EW-1:0] hs_sum, he_sum, ws_sum, we_sum;
  logic [HW-1:0] hs_c, he_c;
  logic [WW-1:0] ws_c, we_c;

  assign hs_sum = EW'(ys) + EW'(rs_q);
  assign he_sum = EW'(ys) + EW'(re_q);
  assign ws_sum = EW'(xs) + EW'(cs_q);
  assign we_sum = EW'(xs) + EW'(ce_q);
  assign hs_c   = (hs_sum > EW'(mh_s)) ? mh_s : HW'(hs_sum);
  assign he_c   = (he_sum > EW'(mh_s)) ? mh_s : HW'(he_sum);
  assign ws_c   = (ws_sum > EW'(mw_s)) ? mw_s : WW'(ws_sum);
  assign we_c   = (we_sum > EW'(mw_s)) ? mw_s : WW'(we_sum);

  // scan position within the current bin
  logic [HW-1:0] fr, he_r;
  logic [WW-1:0] fc, ws_r, we_r;
  logic          row_end, col_end;

  assign col_end = (WW'(fc + WW'(1)) == we_r);
  assign row_end = (HW'(fr + HW'(1)) == he_r);

  always_ff @(posedge clk) begin
    if (cmd.bin_start) begin
      he_r <= he_c;
      ws_r <= ws_c;
      we_r <= we_c;
      fr   <= hs_c;
      fc   <= ws_c;
    end else if (cmd.scan) begin
      if (col_end) begin
        fc <= ws_r;
        fr <= HW'(fr + HW'(1));
      end else begin
        fc <= WW'(fc + WW'(1));
      end
    end
  end

  // feature store: one write port, one registered read port
  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic             wr_en;

  assign wr_en   = cmd.write && (32'(channel) < CHANNELS) && (32'(row) < MAX_ROWS) &&
                   (32'(col) < MAX_COLS);
  assign wr_addr = AW'(AW'(channel) * AW'(PLANE) + AW'(row) * AW'(MAX_COLS) + AW'(col));
  assign rd_addr = AW'(AW'(q_ch) * AW'(PLANE) + AW'(fr) * AW'(MAX_COLS) + AW'(fc));

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= value;
    if (cmd.scan) rdata <= mem[rd_addr];
  end

  // read pipeline and running maximum
  logic                    rd_vld, found;
  logic [HW-1:0]           rd_fr, bfr;
  logic [WW-1:0]           rd_fc, bfc;
  logic signed [VAL_W-1:0] best, rval;

  assign rval = signed'(rdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      found  <= 1'b0;
    end else begin
      rd_vld <= cmd.scan;
      if (cmd.bin_start) found <= 1'b0;
      else if (rd_vld) found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_fr <= fr;
      rd_fc <= fc;
    end
    if (rd_vld && (!found || (rval > best))) begin
      best <= rval;
      bfr  <= rd_fr;
      bfc  <= rd_fc;
    end
  end

  // output register
  logic [31:0] idx_wide;

  assign idx_wide = 32'(bfr) * 32'(mw_s) + 32'(bfc);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      max_value    <= found ? best : '0;
      argmax_index <= found ? signed'(idx_wide[IDX_W-1:0]) : '1;
      bin_row      <= h_cnt;
      bin_col      <= w_cnt;
      last         <= status.last_row && status.last_col;
    end
  end

  // status
  assign status.div_done  = done_h && done_w;
  assign status.bin_empty = !ch_ok || (he_c <= hs_c) || (we_c <= ws_c);
  assign status.scan_last = row_end && col_end;
  assign status.out_free  = !out_valid || !out_stall;
  assign status.last_row  = (h_cnt == BIN_W'(ph_s - 4'd1));
  assign status.last_col  = (w_cnt == BIN_W'(pw_s - 4'd1));

endmodule
`default_nettype wire

[rtl/roi_max_pooling_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// roi_max_pooling_unit
// Region-of-interest max pooling over a stored channel x row x column map.
//
// channel  direction  handshake            payload
// in       input      in_valid/in_stall    opcode channel row col value roi_*
// out      output     out_valid/out_stall  max_value argmax_index bin_row
//                                          bin_col last
// cfg      input      cfg_write            cfg_index cfg_data
//
// Feature writes are taken while the sequencer is idle and stream back to back.
// A query scales the four region coordinates, sizes the region and divides it
// by the pooled counts, then per bin sets up the edges, reads each covered cell
// through the store read port, drains the compare and loads the output register.
// An empty bin skips the scan. A stalled output holds the sequencer.
// Reset clears control state and presets config; no store clearing pass.
// ----------------------------------------------------------------------------
module roi_max_pooling_unit #(
  parameter int CHANNELS   = 8,
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int MAX_POOLED = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                opcode,
  input  wire logic [rmp_pkg::CHAN_W-1:0]          channel,
  input  wire logic [rmp_pkg::POS_W-1:0]           row,
  input  wire logic [rmp_pkg::POS_W-1:0]           col,
  input  wire logic signed [rmp_pkg::VAL_W-1:0]    value,
  input  wire logic [rmp_pkg::COORD_W-1:0]         roi_x_start,
  input  wire logic [rmp_pkg::COORD_W-1:0]         roi_y_start,
  input  wire logic [rmp_pkg::COORD_W-1:0]         roi_x_end,
  input  wire logic [rmp_pkg::COORD_W-1:0]         roi_y_end,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [rmp_pkg::VAL_W-1:0]         max_value,
  output logic signed [rmp_pkg::IDX_W-1:0]         argmax_index,
  output logic [rmp_pkg::BIN_W-1:0]                bin_row,
  output logic [rmp_pkg::BIN_W-1:0]                bin_col,
  output logic                                     last,
  input  wire logic                                cfg_write,
  input  wire logic [rmp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [rmp_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import rmp_pkg::*;

  logic [15:0] scale_reg;
  logic [3:0]  pool_rows, pool_cols;
  logic [6:0]  map_height, map_width;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_reg  <= SCALE_RST;
      pool_rows  <= POOL_RST;
      pool_cols  <= POOL_RST;
      map_height <= MAP_RST;
      map_width  <= MAP_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SCALE:      scale_reg  <= cfg_data;
        REG_POOL_ROWS:  pool_rows  <= cfg_data[3:0];
        REG_POOL_COLS:  pool_cols  <= cfg_data[3:0];
        REG_MAP_HEIGHT: map_height <= cfg_data[6:0];
        REG_MAP_WIDTH:  map_width  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  rmp_cmd_t    cmd;
  rmp_status_t status;

  rmp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .opcode(opcode),
    .in_stall(in_stall), .cmd(cmd), .status(status)
  );

  rmp_dp #(
    .CHANNELS(CHANNELS), .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS),
    .MAX_POOLED(MAX_POOLED)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .cfg_scale(scale_reg), .cfg_ph(pool_rows), .cfg_pw(pool_cols),
    .cfg_mh(map_height), .cfg_mw(map_width),
    .channel(channel), .row(row), .col(col), .value(value),
    .roi_x_start(roi_x_start), .roi_y_start(roi_y_start),
    .roi_x_end(roi_x_end), .roi_y_end(roi_y_end),
    .out_valid(out_valid), .out_stall(out_stall), .max_value(max_value),
    .argmax_index(argmax_index), .bin_row(bin_row), .bin_col(bin_col),
    .last(last)
  );

endmodule
`default_nettype wire

[rtl/rmp_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmp_checker
// Port-level checks of the pooling unit, bound to the top level.
// ----------------------------------------------------------------------------
module rmp_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic signed [15:0] max_value,
  input wire logic signed [12:0] argmax_index,
  input wire logic              last
);

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(max_value) &&
    $stable(argmax_index) && $stable(last))
    else $error("stalled result dropped or changed");

  // an empty bin reports zero
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (argmax_index == -13'sd1) |-> (max_value == 16'sd0))
    else $error("empty bin with nonzero value");

  // the index is a map position or the empty mark
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (argmax_index >= -13'sd1))
    else $error("index below the empty mark");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind roi_max_pooling_unit rmp_checker u_rmp_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .max_value(max_value), .argmax_index(argmax_index), .last(last)
);
`default_nettype wire
